@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms with reset disable
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/rmq_pkg.sv @@
// ---------------------------------------------------------------------------
// rmq_pkg
// widths, constants and shared types of the matrix to quaternion pipeline
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int CW        = 16;
  localparam int FRAC      = 14;
  localparam int ONE       = 16384;
  localparam int EW        = 19;
  localparam int AW        = 17;
  localparam int LANES     = 4;
  localparam int SQW       = 2 * AW;
  localparam int SUMW      = SQW + 2;
  localparam int RADW      = SUMW + 2 * FRAC;
  localparam int ROOTW     = RADW / 2;
  localparam int SQ_STEPS  = ROOTW;
  localparam int DENW      = ROOTW + 1;
  localparam int NUMSH     = 2 * FRAC + 1;
  localparam int NUMW      = AW + NUMSH + 1;
  localparam int QW        = FRAC + 1;
  localparam int DIV_STEPS = QW;

  typedef struct packed {
    logic valid;
    logic bad;
  } ctl_t;

  typedef struct packed {
    logic [LANES-1:0]         neg;
    logic [LANES-1:0][AW-1:0] absv;
  } side_t;

endpackage

@@ hw/rtl/rmq_if.sv @@
// ---------------------------------------------------------------------------
// rmq channel interfaces
// matrix request channel and quaternion result channel
// ---------------------------------------------------------------------------
interface rmq_mat_if;
  logic valid;
  logic ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmq_quat_if;
  logic valid;
  logic ready;
  logic signed [15:0] qw, qx, qy, qz;
  logic invalid;
  modport source (output valid, qw, qx, qy, qz, invalid, input ready);
  modport sink (input valid, qw, qx, qy, qz, invalid, output ready);
endinterface

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix (Q1.14) to normalized quaternion (Q1.14)
//
// mat carries one matrix request, nine signed Q1.14 entries; quat returns
// qw, qx, qy, qz in Q1.14 and an invalid flag (pivot radicand or magnitude
// not positive, components then zero). Each request gives one result.
// From the accepting edge to quat.valid a request passes three stages
// of branch select, squaring and sum, 32 square-root stages (one root bit
// each), one divide setup stage, 15 divide stages (one quotient bit each
// in four lanes) and the output register.
// Throughput is one request per cycle while quat is not stalled; the
// pipeline is fully stage registered with a valid bit per stage.
// Reset clears all valid bits; results in flight are dropped.
// When quat is stalled with a result held, the whole pipeline freezes and
// mat.ready drops in the same cycle; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion (
  input  logic     clk,
  input  logic     rst,
  rmq_mat_if.sink  mat,
  rmq_quat_if.source quat
);

  logic en;

  logic signed [rmq_pkg::EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [rmq_pkg::EW-1:0] tr, rad;
  logic signed [rmq_pkg::EW-1:0] v [rmq_pkg::LANES];
  rmq_pkg::ctl_t                 ctl0;
  rmq_pkg::side_t                side0;

  rmq_pkg::ctl_t                 ctl1, ctl2, ctl3;
  rmq_pkg::side_t                side1, side2, side3;
  logic [rmq_pkg::SQW-1:0]       sq2 [rmq_pkg::LANES];
  logic [rmq_pkg::SUMW-1:0]      sum3;
  logic [rmq_pkg::SUMW-1:0]      sum_c;

  rmq_pkg::ctl_t                 sq_ctl;
  rmq_pkg::side_t                sq_side;
  logic [rmq_pkg::ROOTW-1:0]     sq_root;

  rmq_pkg::ctl_t                               out_ctl;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::CW-1:0]  out_q;

  assign en        = !out_ctl.valid || quat.ready;
  assign mat.ready = en;

  // branch select
  always_comb begin
    e00 = rmq_pkg::EW'(mat.m00);
    e01 = rmq_pkg::EW'(mat.m01);
    e02 = rmq_pkg::EW'(mat.m02);
    e10 = rmq_pkg::EW'(mat.m10);
    e11 = rmq_pkg::EW'(mat.m11);
    e12 = rmq_pkg::EW'(mat.m12);
    e20 = rmq_pkg::EW'(mat.m20);
    e21 = rmq_pkg::EW'(mat.m21);
    e22 = rmq_pkg::EW'(mat.m22);
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      rad  = tr + rmq_pkg::EW'(rmq_pkg::ONE);
      v[0] = rad;
      v[1] = e12 - e21;
      v[2] = e20 - e02;
      v[3] = e01 - e10;
    end else if (e00 > e11 && e00 > e22) begin
      rad  = rmq_pkg::EW'(rmq_pkg::ONE) + e00 - e11 - e22;
      v[0] = e12 - e21;
      v[1] = rad;
      v[2] = e10 + e01;
      v[3] = e20 + e02;
    end else if (e11 > e22) begin
      rad  = rmq_pkg::EW'(rmq_pkg::ONE) + e11 - e00 - e22;
      v[0] = e20 - e02;
      v[1] = e10 + e01;
      v[2] = rad;
      v[3] = e21 + e12;
    end else begin
      rad  = rmq_pkg::EW'(rmq_pkg::ONE) + e22 - e11 - e00;
      v[0] = e01 - e10;
      v[1] = e20 + e02;
      v[2] = e12 + e21;
      v[3] = rad;
    end
    ctl0.valid = mat.valid;
    ctl0.bad   = (rad <= 0);
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      side0.neg[l]  = v[l][rmq_pkg::EW-1];
      side0.absv[l] = v[l][rmq_pkg::EW-1] ? rmq_pkg::AW'(-v[l])
                                          : rmq_pkg::AW'(v[l]);
    end
  end

  always_comb begin
    sum_c = '0;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      sum_c = sum_c + rmq_pkg::SUMW'(sq2[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else if (en) begin
      ctl1 <= ctl0;
      ctl2 <= ctl1;
      ctl3 <= '{valid: ctl2.valid, bad: ctl2.bad || (sum_c == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side0;
      side2 <= side1;
      side3 <= side2;
      for (int l = 0; l < rmq_pkg::LANES; l++) begin
        sq2[l] <= side1.absv[l] * side1.absv[l];
      end
      sum3 <= sum_c;
    end
  end

  rmq_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (ctl3),
    .in_side  (side3),
    .in_sum   (sum3),
    .out_ctl  (sq_ctl),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  rmq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (sq_ctl),
    .in_side (sq_side),
    .in_root (sq_root),
    .out_ctl (out_ctl),
    .out_q   (out_q)
  );

  assign quat.valid   = out_ctl.valid;
  assign quat.invalid = out_ctl.bad;
  assign quat.qw      = out_q[0];
  assign quat.qx      = out_q[1];
  assign quat.qy      = out_q[2];
  assign quat.qz      = out_q[3];

  `RMQ_ASSERT_IMP(a_bad_zero, quat.valid && quat.invalid,
    quat.qw == 0 && quat.qx == 0 && quat.qy == 0 && quat.qz == 0,
    "invalid result with nonzero components")
  `RMQ_ASSERT_IMP(a_good_nonzero, quat.valid && !quat.invalid,
    !(quat.qw == 0 && quat.qx == 0 && quat.qy == 0 && quat.qz == 0),
    "valid result with all components zero")
  `RMQ_ASSERT_IMP(a_unit_range, quat.valid,
    quat.qw <= 16384 && quat.qw >= -16384 && quat.qx <= 16384 && quat.qx >= -16384 &&
    quat.qy <= 16384 && quat.qy >= -16384 && quat.qz <= 16384 && quat.qz >= -16384,
    "component outside unit range")

endmodule

@@ hw/rtl/rmq_isqrt.sv @@
// ---------------------------------------------------------------------------
// rmq_isqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module rmq_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  rmq_pkg::ctl_t                 in_ctl,
  input  rmq_pkg::side_t                in_side,
  input  logic [rmq_pkg::SUMW-1:0]      in_sum,
  output rmq_pkg::ctl_t                 out_ctl,
  output rmq_pkg::side_t                out_side,
  output logic [rmq_pkg::ROOTW-1:0]     out_root
);

  rmq_pkg::ctl_t              ctl_q  [rmq_pkg::SQ_STEPS];
  rmq_pkg::side_t             side_q [rmq_pkg::SQ_STEPS];
  logic [rmq_pkg::RADW-1:0]   rem_q  [rmq_pkg::SQ_STEPS];
  logic [rmq_pkg::RADW-1:0]   res_q  [rmq_pkg::SQ_STEPS];

  for (genvar j = 0; j < rmq_pkg::SQ_STEPS; j++) begin : g_step
    rmq_pkg::ctl_t            ctl_i;
    rmq_pkg::side_t           side_i;
    logic [rmq_pkg::RADW-1:0] rem_i, res_i, bit_c, trial;

    if (j == 0) begin : g_first
      assign ctl_i  = in_ctl;
      assign side_i = in_side;
      assign rem_i  = {in_sum, {(2 * rmq_pkg::FRAC){1'b0}}};
      assign res_i  = '0;
    end else begin : g_next
      assign ctl_i  = ctl_q[j-1];
      assign side_i = side_q[j-1];
      assign rem_i  = rem_q[j-1];
      assign res_i  = res_q[j-1];
    end

    assign bit_c = rmq_pkg::RADW'(1) << (rmq_pkg::RADW - 2 - 2 * j);
    assign trial = res_i + bit_c;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[j] <= '0;
      end else if (en) begin
        ctl_q[j] <= ctl_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= side_i;
        if (rem_i >= trial) begin
          rem_q[j] <= rem_i - trial;
          res_q[j] <= (res_i >> 1) + bit_c;
        end else begin
          rem_q[j] <= rem_i;
          res_q[j] <= res_i >> 1;
        end
      end
    end
  end

  assign out_ctl  = ctl_q[rmq_pkg::SQ_STEPS-1];
  assign out_side = side_q[rmq_pkg::SQ_STEPS-1];
  assign out_root = res_q[rmq_pkg::SQ_STEPS-1][rmq_pkg::ROOTW-1:0];

endmodule

@@ hw/rtl/rmq_div.sv @@
// ---------------------------------------------------------------------------
// rmq_div
// four-lane pipelined restoring divide by twice the magnitude, with rounding,
// clamp to one, sign restore, zeroing of bad results and output register
// ---------------------------------------------------------------------------
module rmq_div (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  rmq_pkg::ctl_t                               in_ctl,
  input  rmq_pkg::side_t                              in_side,
  input  logic [rmq_pkg::ROOTW-1:0]                   in_root,
  output rmq_pkg::ctl_t                               out_ctl,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::CW-1:0]  out_q
);

  rmq_pkg::ctl_t              pre_ctl;
  logic [rmq_pkg::LANES-1:0]  pre_neg;
  logic [rmq_pkg::DENW-1:0]   pre_den;
  logic [rmq_pkg::NUMW-1:0]   pre_num [rmq_pkg::LANES];

  rmq_pkg::ctl_t              ctl_q [rmq_pkg::DIV_STEPS];
  logic [rmq_pkg::LANES-1:0]  neg_q [rmq_pkg::DIV_STEPS];
  logic [rmq_pkg::DENW-1:0]   den_q [rmq_pkg::DIV_STEPS];
  logic [rmq_pkg::NUMW-1:0]   rem_q [rmq_pkg::DIV_STEPS][rmq_pkg::LANES];
  logic [rmq_pkg::QW-1:0]     quo_q [rmq_pkg::DIV_STEPS][rmq_pkg::LANES];

  rmq_pkg::ctl_t                               fin_ctl;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::CW-1:0]  fin_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_ctl <= '0;
    end else if (en) begin
      pre_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_neg <= in_side.neg;
      pre_den <= {in_root, 1'b0};
      for (int l = 0; l < rmq_pkg::LANES; l++) begin
        pre_num[l] <= ({{(rmq_pkg::NUMW - rmq_pkg::AW){1'b0}}, in_side.absv[l]}
                       << rmq_pkg::NUMSH)
                      + {{(rmq_pkg::NUMW - rmq_pkg::ROOTW){1'b0}}, in_root};
      end
    end
  end

  for (genvar j = 0; j < rmq_pkg::DIV_STEPS; j++) begin : g_step
    rmq_pkg::ctl_t              ctl_i;
    logic [rmq_pkg::LANES-1:0]  neg_i;
    logic [rmq_pkg::DENW-1:0]   den_i;
    logic [rmq_pkg::NUMW-1:0]   rem_i [rmq_pkg::LANES];
    logic [rmq_pkg::QW-1:0]     quo_i [rmq_pkg::LANES];
    logic [rmq_pkg::NUMW-1:0]   sub;

    if (j == 0) begin : g_first
      assign ctl_i = pre_ctl;
      assign neg_i = pre_neg;
      assign den_i = pre_den;
      for (genvar l = 0; l < rmq_pkg::LANES; l++) begin : g_lane
        assign rem_i[l] = pre_num[l];
        assign quo_i[l] = '0;
      end
    end else begin : g_next
      assign ctl_i = ctl_q[j-1];
      assign neg_i = neg_q[j-1];
      assign den_i = den_q[j-1];
      for (genvar l = 0; l < rmq_pkg::LANES; l++) begin : g_lane
        assign rem_i[l] = rem_q[j-1][l];
        assign quo_i[l] = quo_q[j-1][l];
      end
    end

    assign sub = {{(rmq_pkg::NUMW - rmq_pkg::DENW){1'b0}}, den_i}
                 << (rmq_pkg::DIV_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[j] <= '0;
      end else if (en) begin
        ctl_q[j] <= ctl_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_q[j] <= neg_i;
        den_q[j] <= den_i;
        for (int l = 0; l < rmq_pkg::LANES; l++) begin
          if (rem_i[l] >= sub) begin
            rem_q[j][l] <= rem_i[l] - sub;
            quo_q[j][l] <= {quo_i[l][rmq_pkg::QW-2:0], 1'b1};
          end else begin
            rem_q[j][l] <= rem_i[l];
            quo_q[j][l] <= {quo_i[l][rmq_pkg::QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    logic [rmq_pkg::QW-1:0] q;
    logic [rmq_pkg::CW-1:0] qe;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      q = quo_q[rmq_pkg::DIV_STEPS-1][l];
      if (q > rmq_pkg::QW'(rmq_pkg::ONE)) begin
        q = rmq_pkg::QW'(rmq_pkg::ONE);
      end
      qe = {1'b0, q};
      if (ctl_q[rmq_pkg::DIV_STEPS-1].bad) begin
        fin_q[l] = '0;
      end else if (neg_q[rmq_pkg::DIV_STEPS-1][l]) begin
        fin_q[l] = -qe;
      end else begin
        fin_q[l] = qe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_ctl <= '0;
    end else if (en) begin
      fin_ctl <= ctl_q[rmq_pkg::DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= fin_q;
    end
  end

  assign out_ctl = fin_ctl;

endmodule
